// File: hw/rtl/tlps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlps_pkg
// Shared types and constants of the timed light pattern sequencer.
// ----------------------------------------------------------------------------
package tlps_pkg;

  localparam int MAX_ROWS     = 16;
  localparam int IDX_W        = $clog2(MAX_ROWS);
  localparam int CNT_W        = $clog2(MAX_ROWS + 1);
  localparam int PATTERN_BITS = 16;
  localparam int DUR_W        = 16;
  localparam int TIME_W       = 32;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  typedef struct packed {
    logic [PATTERN_BITS-1:0] pattern;
    logic [DUR_W-1:0]        duration;
  } row_t;

endpackage

// File: hw/rtl/tlps_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlps_row_mem
// Row table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlps_row_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [tlps_pkg::IDX_W-1:0] waddr,
  input  tlps_pkg::row_t           wdata,
  input  logic                     re,
  input  logic [tlps_pkg::IDX_W-1:0] raddr,
  output tlps_pkg::row_t           rdata
);

  tlps_pkg::row_t mem [tlps_pkg::MAX_ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/timed_light_pattern_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_light_pattern_sequencer
// Row table of light patterns and durations, stepped by elapsed time.
// ----------------------------------------------------------------------------
// Add, restart and advance each go from S_EXEC to S_CHECK, or straight to
// done when no row is current; in S_CHECK every row stepped over waits on
// one read of the row table. A new request is taken only while busy is low.
// Reset clears row count, index and elapsed time; table contents stay
// undefined until written. Results are shown for one cycle on done and
// cannot be held off.
// ----------------------------------------------------------------------------
module timed_light_pattern_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         opcode,
  input  logic [tlps_pkg::PATTERN_BITS-1:0]  pattern_in,
  input  logic [tlps_pkg::DUR_W-1:0]         duration_in,
  input  logic [15:0]                        advance_ms,
  output logic                               done,
  output logic [tlps_pkg::PATTERN_BITS-1:0]  pattern_out,
  output logic                               active
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t state;

  logic [1:0]                        op;
  tlps_pkg::row_t                    req_row;
  logic [15:0]                       adv;
  logic [tlps_pkg::CNT_W-1:0]        rows_loaded;
  logic [tlps_pkg::CNT_W-1:0]        current_index;
  logic [tlps_pkg::TIME_W-1:0]       time_in_row;
  logic                              fwd;

  logic                              table_full;
  logic                              do_write;
  logic [tlps_pkg::CNT_W-1:0]        rows_next;
  logic [tlps_pkg::CNT_W-1:0]        index_next;
  logic [tlps_pkg::CNT_W-1:0]        index_inc;
  logic [tlps_pkg::TIME_W:0]         sum;
  logic                              rd_en;
  logic [tlps_pkg::IDX_W-1:0]        rd_addr;
  tlps_pkg::row_t                    rd_data;
  tlps_pkg::row_t                    cur_row;
  logic                              step;

  assign busy       = (state != S_IDLE);
  assign table_full = (rows_loaded == tlps_pkg::CNT_W'(tlps_pkg::MAX_ROWS));
  assign do_write   = (state == S_EXEC) && (op == tlps_pkg::OP_ADD) && !table_full;
  assign rows_next  = do_write ? rows_loaded + 1'b1 : rows_loaded;
  assign index_next = (op == tlps_pkg::OP_RESTART) ? '0 : current_index;
  assign index_inc  = current_index + 1'b1;
  assign sum        = {1'b0, time_in_row} + {{(tlps_pkg::TIME_W - 15){1'b0}}, adv};
  // the row just written cannot come back from the read port in the same cycle
  assign cur_row    = fwd ? req_row : rd_data;
  assign step       = (op == tlps_pkg::OP_ADVANCE) &&
                      (time_in_row > {{(tlps_pkg::TIME_W - tlps_pkg::DUR_W){1'b0}},
                                      cur_row.duration});

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = index_next[tlps_pkg::IDX_W-1:0];
    case (state)
      S_EXEC: begin
        rd_en = 1'b1;
      end
      S_CHECK: begin
        rd_en   = step;
        rd_addr = index_inc[tlps_pkg::IDX_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  tlps_row_mem u_row_mem (
    .clk   (clk),
    .we    (do_write),
    .waddr (rows_loaded[tlps_pkg::IDX_W-1:0]),
    .wdata (req_row),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rows_loaded   <= '0;
      current_index <= '0;
      time_in_row   <= '0;
      done          <= 1'b0;
      fwd           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op      <= opcode;
            req_row <= '{pattern: pattern_in, duration: duration_in};
            adv     <= advance_ms;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          rows_loaded   <= rows_next;
          current_index <= index_next;
          fwd           <= do_write && (index_next == rows_loaded);
          if (op == tlps_pkg::OP_RESTART) begin
            time_in_row <= '0;
          end else if (op == tlps_pkg::OP_ADVANCE) begin
            // saturate on carry out
            time_in_row <= sum[tlps_pkg::TIME_W] ? '1 : sum[tlps_pkg::TIME_W-1:0];
          end
          if (index_next < rows_next) begin
            state <= S_CHECK;
          end else begin
            pattern_out <= '0;
            active      <= 1'b0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (step) begin
            time_in_row   <= time_in_row -
                             {{(tlps_pkg::TIME_W - tlps_pkg::DUR_W){1'b0}}, cur_row.duration};
            current_index <= index_inc;
            fwd           <= 1'b0;
            if (index_inc >= rows_loaded) begin
              pattern_out <= '0;
              active      <= 1'b0;
              done        <= 1'b1;
              state       <= S_IDLE;
            end
          end else begin
            pattern_out <= cur_row.pattern;
            active      <= 1'b1;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    current_index <= rows_loaded)
    else $error("current row beyond loaded rows");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

endmodule

// File: tb/sv/timed_light_pattern_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_light_pattern_sequencer_test
// Self-checking bench for the light pattern sequencer. A stimulus table
// covers the empty table, zero and maximum durations, rows that end exactly
// on their duration, multi-row steps, adds after the sequence has finished
// and the unused opcode. A random phase then fills the table and steps
// through it with random pauses on the request side. Every result is
// compared against a behavioural prediction or a typed expected value.
// ----------------------------------------------------------------------------
module timed_light_pattern_sequencer_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 1650;
  localparam int QUIET_TAIL  = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [tlps_pkg::PATTERN_BITS-1:0] pattern;
    logic                              active;
  } status_t;

  typedef struct packed {
    logic [1:0]                        op;
    logic [tlps_pkg::PATTERN_BITS-1:0] pat;
    logic [tlps_pkg::DUR_W-1:0]        dur;
    logic [15:0]                       adv;
    logic                              typed;
    status_t                           status;
  } vector_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        opcode = tlps_pkg::OP_ADVANCE;
  logic [tlps_pkg::PATTERN_BITS-1:0] pattern_in = '0;
  logic [tlps_pkg::DUR_W-1:0]        duration_in = '0;
  logic [15:0]                       advance_ms = '0;
  logic                              done;
  logic [tlps_pkg::PATTERN_BITS-1:0] pattern_out;
  logic                              active;

  // predicted sequencer state
  logic [tlps_pkg::PATTERN_BITS-1:0] tbl_pattern [tlps_pkg::MAX_ROWS];
  logic [tlps_pkg::DUR_W-1:0]        tbl_duration [tlps_pkg::MAX_ROWS];
  int                                n_rows = 0;
  int                                cur_row = 0;
  logic [tlps_pkg::TIME_W-1:0]       row_time = '0;

  status_t pending_status [$];
  vector_t directed [$];
  int      err_count = 0;
  int      quiet_cycles = 0;

  timed_light_pattern_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .pattern_in  (pattern_in),
    .duration_in (duration_in),
    .advance_ms  (advance_ms),
    .done        (done),
    .pattern_out (pattern_out),
    .active      (active)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic status_t next_status(input logic [1:0] op,
                                          input logic [tlps_pkg::PATTERN_BITS-1:0] pat,
                                          input logic [tlps_pkg::DUR_W-1:0] dur,
                                          input logic [15:0] adv);
    logic [tlps_pkg::TIME_W:0] sum;
    status_t                   s;
    case (op)
      tlps_pkg::OP_ADD: begin
        if (n_rows < tlps_pkg::MAX_ROWS) begin
          tbl_pattern[n_rows] = pat;
          tbl_duration[n_rows] = dur;
          n_rows++;
        end
      end
      tlps_pkg::OP_RESTART: begin
        cur_row = 0;
        row_time = '0;
      end
      tlps_pkg::OP_ADVANCE: begin
        sum = {1'b0, row_time} + adv;
        row_time = sum[tlps_pkg::TIME_W] ? '1 : sum[tlps_pkg::TIME_W-1:0];
        // advance while the elapsed time overruns the current row
        while (cur_row < n_rows &&
               row_time > tlps_pkg::TIME_W'(tbl_duration[cur_row])) begin
          row_time = row_time - tlps_pkg::TIME_W'(tbl_duration[cur_row]);
          cur_row++;
        end
      end
      default: ;
    endcase
    if (cur_row < n_rows) begin
      s.pattern = tbl_pattern[cur_row];
      s.active = 1'b1;
    end else begin
      s.pattern = '0;
      s.active = 1'b0;
    end
    return s;
  endfunction

  task automatic send_request(input logic [1:0] op,
                              input logic [tlps_pkg::PATTERN_BITS-1:0] pat,
                              input logic [tlps_pkg::DUR_W-1:0] dur, input logic [15:0] adv,
                              input logic typed, input status_t typed_status);
    status_t predicted;
    start <= 1'b1;
    opcode <= op;
    pattern_in <= pat;
    duration_in <= dur;
    advance_ms <= adv;
    do @(posedge clk); while (busy);
    predicted = next_status(op, pat, dur, adv);
    pending_status.push_back(typed ? typed_status : predicted);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic add_vector(input logic [1:0] op,
                            input logic [tlps_pkg::PATTERN_BITS-1:0] pat,
                            input logic [tlps_pkg::DUR_W-1:0] dur, input logic [15:0] adv,
                            input logic typed,
                            input logic [tlps_pkg::PATTERN_BITS-1:0] exp_pat,
                            input logic exp_act);
    vector_t v;
    v.op = op;
    v.pat = pat;
    v.dur = dur;
    v.adv = adv;
    v.typed = typed;
    v.status.pattern = exp_pat;
    v.status.active = exp_act;
    directed.push_back(v);
  endtask

  // result checker
  always @(posedge clk) begin
    status_t want;
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, got pattern %h active %b",
                   $time, pattern_out, active);
      end else begin
        want = pending_status.pop_front();
        if (pattern_out !== want.pattern) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t pattern_out: expected %h, got %h", $time, want.pattern,
                     pattern_out);
        end
        if (active !== want.active) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t active: expected %b, got %b", $time, want.active, active);
        end
      end
    end
  end

  // watchdog on cycles with neither a request nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0]                        op;
    logic [tlps_pkg::PATTERN_BITS-1:0] pat;
    logic [tlps_pkg::DUR_W-1:0]        dur;
    logic [15:0]                       adv;
    int                                pick;
    bit                                idle_on;

    // empty table
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd0, 1'b1, 16'h0000, 1'b0);
    add_vector(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0);
    add_vector(tlps_pkg::OP_RESTART, 16'h1111, 16'h2222, 16'h3333, 1'b1, 16'h0000, 1'b0);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd10, 1'b1, 16'h0000, 1'b0);
    // first row keeps the time already elapsed
    add_vector(tlps_pkg::OP_ADD, 16'hFFFF, 16'd0, 16'd0, 1'b1, 16'hFFFF, 1'b1);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd0, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_RESTART, 16'h0000, 16'h0000, 16'd0, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADD, 16'h0000, 16'hFFFF, 16'd0, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADD, 16'hA5A5, 16'd3, 16'd0, 1'b0, '0, 1'b0);
    // time equal to the duration holds the row
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd0, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd1, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd2, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd1, 1'b0, '0, 1'b0);
    add_vector(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0);
    // finished: time still runs, then a late row picks it up
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADD, 16'h5A5A, 16'd7, 16'd0, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'd0, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_RESTART, 16'h0000, 16'h0000, 16'd0, 1'b0, '0, 1'b0);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0, 1'b0);
    // one advance steps over three rows
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0, 1'b0);
    // leftover time plus a full-range advance overruns even the longest row
    add_vector(tlps_pkg::OP_ADD, 16'h8001, 16'hFFFF, 16'd0, 1'b1, 16'h8001, 1'b1);
    add_vector(tlps_pkg::OP_ADVANCE, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_request(directed[i].op, directed[i].pat, directed[i].dur, directed[i].adv,
                   directed[i].typed, directed[i].status);
      if ($urandom_range(0, 2) == 0)
        pause($urandom_range(1, 12));
    end

    idle_on = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 50 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 65)
        op = tlps_pkg::OP_ADVANCE;
      else if (pick < 80)
        op = tlps_pkg::OP_RESTART;
      else if (pick < 95)
        op = tlps_pkg::OP_ADD;
      else
        op = OP_UNUSED;
      pat = tlps_pkg::PATTERN_BITS'($urandom);
      dur = ($urandom_range(0, 3) == 0) ? tlps_pkg::DUR_W'($urandom)
                                        : tlps_pkg::DUR_W'($urandom_range(0, 40));
      adv = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
      send_request(op, pat, dur, adv, 1'b0, '0);
      if (idle_on && i < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 12));
    end
    start <= 1'b0;

    while (pending_status.size() != 0)
      @(posedge clk);
    // hold for the longest step sequence before the verdict
    repeat (2 + tlps_pkg::MAX_ROWS + 8) @(posedge clk);

    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
